/* rtl/fau_pkg.sv */
// Shared types, command codes and unpacking helpers for the float32 arithmetic unit.
// Used by every module of the unit; depends on nothing.
package fau_pkg;

   // Operation codes carried by the command field
   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_MUL  = 3'd2,
      CMD_DIV  = 3'd3,
      CMD_FTOI = 3'd4,
      CMD_ITOF = 3'd5
   } fau_cmd_type;

   // Operand class after unpacking
   typedef enum logic [1:0] {
      KIND_ZERO      = 2'd0,
      KIND_NORMAL    = 2'd1,
      KIND_SUBNORMAL = 2'd2,
      KIND_SPECIAL   = 2'd3
   } fau_kind_type;

   localparam logic [31:0] SignMask  = 32'h8000_0000;
   localparam logic [31:0] IntMax    = 32'h7fff_ffff;
   localparam logic [31:0] PosInf    = 32'h7f80_0000;
   localparam int          DivSteps  = 49;  // quotient bits of (sig << 24) / sig

   // Unpacked operand: significand has its leading one at bit 24
   typedef struct packed {
      fau_kind_type       kind;
      logic               sign;
      logic signed [9:0]  expo;
      logic [24:0]        sig;
   } fau_unp_type;

   // One item as it travels through the divider cells and the packer
   typedef struct packed {
      logic               valid;
      logic               div_op;
      logic               bypass;
      logic [31:0]        word;
      logic               sign;
      logic signed [11:0] expo;
      logic [31:0]        mant;
      logic [24:0]        rem;
      logic [24:0]        dvd;
      logic [24:0]        dsr;
   } fau_item_type;

   // Split a float bit pattern into class, sign, exponent and significand
   function automatic fau_unp_type fau_unpack(input logic [31:0] w);
      fau_unp_type u;
      logic [7:0]  ef;
      logic [22:0] mf;
      logic [4:0]  msb;
      ef  = w[30:23];
      mf  = w[22:0];
      msb = 5'd0;
      for (int k = 0; k < 23; k++) begin
         if (mf[k]) msb = 5'(k);
      end
      u.sign = w[31];
      if (ef == 8'd0) begin
         if (mf == 23'd0) begin
            u.kind = KIND_ZERO;
            u.expo = -10'sd128;
            u.sig  = 25'd0;
         end else begin
            u.kind = KIND_SUBNORMAL;
            u.expo = $signed({5'd0, msb}) - 10'sd150;
            u.sig  = {2'b00, mf} << (5'd24 - msb);
         end
      end else if (ef == 8'hff) begin
         u.kind = KIND_SPECIAL;
         u.expo = 10'sd255;
         u.sig  = {2'b00, mf};
      end else begin
         u.kind = KIND_NORMAL;
         u.expo = $signed({2'b00, ef}) - 10'sd128;
         u.sig  = {1'b1, mf, 1'b0};
      end
      return u;
   endfunction

   // Position of the highest set bit of a 32-bit word (0 when none)
   function automatic logic [4:0] fau_msb32(input logic [31:0] v);
      logic [4:0] idx;
      idx = 5'd0;
      for (int k = 0; k < 32; k++) begin
         if (v[k]) idx = 5'(k);
      end
      return idx;
   endfunction

endpackage

/* rtl/fau_front.sv */
// Front end of the float32 arithmetic unit: unpack, align/multiply, combine.
// Three register stages; while en is high, hands one fau_item_type per cycle to the divider cells.
// Depends on fau_pkg.
module fau_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [2:0]           command,
   input  logic [31:0]          operand_a,
   input  logic [31:0]          operand_b,
   output fau_pkg::fau_item_type item_out
);
   import fau_pkg::*;

   // stage 1 registers
   logic        s1_valid_ff, s1_valid_in;
   fau_cmd_type s1_cmd_ff, s1_cmd_in;
   logic [31:0] s1_a_ff, s1_a_in;
   fau_unp_type s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic [31:0] s1_iabs_ff, s1_iabs_in;
   logic        s1_isign_ff, s1_isign_in;

   // stage 2 registers
   logic               s2_valid_ff, s2_valid_in;
   fau_cmd_type        s2_cmd_ff, s2_cmd_in;
   logic               s2_xs_ff, s2_xs_in, s2_ys_ff, s2_ys_in;
   logic               s2_s_ff, s2_s_in;
   logic signed [11:0] s2_e_ff, s2_e_in;
   logic [24:0]        s2_ax_ff, s2_ax_in, s2_ay_ff, s2_ay_in;
   logic [49:0]        s2_prod_ff, s2_prod_in;
   logic [4:0]         s2_lz_ff, s2_lz_in;
   logic [31:0]        s2_iabs_ff, s2_iabs_in;
   logic [31:0]        s2_word_ff, s2_word_in;

   // stage 3 register
   fau_item_type item_ff, item_in;

   // internal stage 2 terms
   logic signed [10:0] ediff;
   logic [10:0]        align_sh;
   logic               far;
   logic [24:0]        shifted;
   logic signed [9:0]  ue;
   logic [31:0]        mag, sat;
   // internal stage 3 terms
   logic [25:0]        mc;

   // Stage 1: unpack both operands, take integer magnitude
   always_comb begin
      s1_valid_in = in_valid;
      s1_cmd_in   = fau_cmd_type'(command);
      s1_a_in     = operand_a;
      s1_x_in     = fau_unpack(operand_a);
      s1_y_in     = fau_unpack((s1_cmd_in == CMD_SUB) ? (operand_b ^ SignMask) : operand_b);
      s1_isign_in = operand_a[31];
      s1_iabs_in  = operand_a[31] ? (32'd0 - operand_a) : operand_a;
   end

   // Stage 2: exponent alignment, product, exponents, float-to-int, int-to-float leading one
   always_comb begin
      ediff    = 11'(s1_x_ff.expo) - 11'(s1_y_ff.expo);
      align_sh = ediff[10] ? 11'(-ediff) : ediff;
      far      = (align_sh >= 11'd25);
      shifted  = far ? 25'd0
                     : ((ediff[10] ? s1_x_ff.sig : s1_y_ff.sig) >> align_sh[4:0]);

      s2_valid_in = s1_valid_ff;
      s2_cmd_in   = s1_cmd_ff;
      s2_xs_in    = s1_x_ff.sign;
      s2_ys_in    = s1_y_ff.sign;
      s2_prod_in  = 50'(s1_x_ff.sig) * 50'(s1_y_ff.sig);
      s2_lz_in    = fau_msb32(s1_iabs_ff);
      s2_iabs_in  = s1_iabs_ff;
      s2_s_in     = s1_x_ff.sign ^ s1_y_ff.sign;
      s2_ax_in    = s1_x_ff.sig;
      s2_ay_in    = s1_y_ff.sig;
      s2_e_in     = 12'sd0;
      case (s1_cmd_ff) inside
         CMD_ADD, CMD_SUB: begin
            s2_ax_in = ediff[10] ? shifted : s1_x_ff.sig;
            s2_ay_in = ediff[10] ? s1_y_ff.sig : shifted;
            s2_e_in  = ediff[10] ? 12'(s1_y_ff.expo) : 12'(s1_x_ff.expo);
         end
         CMD_MUL:  s2_e_in = 12'(s1_x_ff.expo) + 12'(s1_y_ff.expo) + 12'sd2;
         CMD_DIV:  s2_e_in = 12'(s1_x_ff.expo) - 12'(s1_y_ff.expo) - 12'sd1;
         CMD_ITOF: begin
            s2_s_in = s1_isign_ff;
            s2_e_in = $signed({7'd0, s2_lz_in});
         end
         default: ;
      endcase

      // float to int: truncate, apply sign, saturate
      ue  = s1_x_ff.expo + 10'sd1;
      sat = s1_x_ff.sign ? SignMask : IntMax;
      mag = 32'd0;
      if (ue >= 10'sd0 && ue <= 10'sd24) begin
         mag = {7'd0, s1_x_ff.sig >> (5'd24 - ue[4:0])};
      end else if (ue > 10'sd24 && ue < 10'sd31) begin
         mag = {7'd0, s1_x_ff.sig} << (ue[4:0] - 5'd24);
      end
      case (s1_x_ff.kind)
         KIND_SPECIAL: s2_word_in = (s1_x_ff.sig != 25'd0) ? s1_a_ff : sat;
         KIND_NORMAL:  s2_word_in = (ue >= 10'sd31) ? sat
                                  : (s1_x_ff.sign ? (32'd0 - mag) : mag);
         default:      s2_word_in = 32'd0;
      endcase
   end

   // Stage 3: add/subtract, product select, int-to-float normalize, divider setup
   always_comb begin
      mc              = 26'd0;
      item_in         = '0;
      item_in.valid   = s2_valid_ff;
      item_in.sign    = s2_s_ff;
      item_in.expo    = s2_e_ff;
      item_in.dvd     = s2_ax_ff;
      item_in.dsr     = s2_ay_ff;
      case (s2_cmd_ff) inside
         CMD_ADD, CMD_SUB: begin
            if (s2_xs_ff == s2_ys_ff) begin
               mc = {1'b0, s2_ax_ff} + {1'b0, s2_ay_ff};
               item_in.sign = s2_xs_ff;
            end else if (s2_ax_ff >= s2_ay_ff) begin
               mc = {1'b0, s2_ax_ff} - {1'b0, s2_ay_ff};
               item_in.sign = s2_xs_ff;
            end else begin
               mc = {1'b0, s2_ay_ff} - {1'b0, s2_ax_ff};
               item_in.sign = s2_ys_ff;
            end
            item_in.mant = 32'(mc);
         end
         CMD_MUL: item_in.mant = 32'(s2_prod_ff[49:25]);
         CMD_DIV: begin
            if (s2_ay_ff == 25'd0) begin
               item_in.bypass = 1'b1;
               item_in.word   = PosInf;
            end else begin
               item_in.div_op = 1'b1;
            end
         end
         CMD_FTOI: begin
            item_in.bypass = 1'b1;
            item_in.word   = s2_word_ff;
         end
         CMD_ITOF: begin
            item_in.mant = (s2_lz_ff > 5'd23) ? (s2_iabs_ff >> (s2_lz_ff - 5'd23))
                                              : (s2_iabs_ff << (5'd23 - s2_lz_ff));
         end
         default: begin
            item_in.bypass = 1'b1;
            item_in.word   = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
         s1_cmd_ff   <= s1_cmd_in;
         s1_a_ff     <= s1_a_in;
         s1_x_ff     <= s1_x_in;
         s1_y_ff     <= s1_y_in;
         s1_iabs_ff  <= s1_iabs_in;
         s1_isign_ff <= s1_isign_in;
         s2_valid_ff <= s2_valid_in;
         s2_cmd_ff   <= s2_cmd_in;
         s2_xs_ff    <= s2_xs_in;
         s2_ys_ff    <= s2_ys_in;
         s2_s_ff     <= s2_s_in;
         s2_e_ff     <= s2_e_in;
         s2_ax_ff    <= s2_ax_in;
         s2_ay_ff    <= s2_ay_in;
         s2_prod_ff  <= s2_prod_in;
         s2_lz_ff    <= s2_lz_in;
         s2_iabs_ff  <= s2_iabs_in;
         s2_word_ff  <= s2_word_in;
         item_ff     <= item_in;
      end
   end

   assign item_out = item_ff;

endmodule

/* rtl/fau_div_cell.sv */
// One restoring-division cell: produces one quotient bit per item and passes it on.
// Items that are not divides ride through unchanged. Depends on fau_pkg.
module fau_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  fau_pkg::fau_item_type up_item,
   output fau_pkg::fau_item_type dn_item
);
   import fau_pkg::*;

   fau_item_type item_ff, item_in;
   logic [25:0]  part;
   logic [26:0]  diff;
   logic         ge;

   // Shift in the next dividend bit, trial subtract the divisor
   always_comb begin
      part    = {up_item.rem, up_item.dvd[24]};
      diff    = {1'b0, part} - {2'b00, up_item.dsr};
      ge      = ~diff[26];
      item_in = up_item;
      if (up_item.div_op) begin
         item_in.rem  = ge ? diff[24:0] : part[24:0];
         item_in.dvd  = {up_item.dvd[23:0], 1'b0};
         item_in.mant = {up_item.mant[30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) item_ff.valid <= 1'b0;
      else if (en) item_ff <= item_in;
   end

   assign dn_item = item_ff;

endmodule

/* rtl/fau_pack.sv */
// Result packer: normalize, round (guard and LSB both set), range-limit, build the word.
// Two register stages; the final word is formed combinationally. Depends on fau_pkg.
module fau_pack (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  fau_pkg::fau_item_type item_in_up,
   output logic                  out_valid,
   output logic [31:0]           out_word
);
   import fau_pkg::*;

   // stage 1 registers
   logic               p1_valid_ff, p1_valid_in;
   logic               p1_bypass_ff, p1_bypass_in;
   logic [31:0]        p1_word_ff, p1_word_in;
   logic               p1_sign_ff, p1_sign_in;
   logic               p1_zero_ff, p1_zero_in;
   logic               p1_up_ff, p1_up_in;
   logic [4:0]         p1_sh_ff, p1_sh_in;
   logic signed [11:0] p1_e_ff, p1_e_in;
   logic [31:0]        p1_m_ff, p1_m_in;

   // stage 2 registers
   logic               p2_valid_ff, p2_valid_in;
   logic               p2_bypass_ff, p2_bypass_in;
   logic [31:0]        p2_word_ff, p2_word_in;
   logic               p2_sign_ff, p2_sign_in;
   logic               p2_zero_ff, p2_zero_in;
   logic signed [11:0] p2_e_ff, p2_e_in;
   logic [31:0]        p2_m_ff, p2_m_in;

   logic [31:0]        m1, m2, m3;
   logic signed [11:0] e1, e2, sub_sh;
   logic [7:0]         ef;

   // Stage 1: locate the leading one within the low 26 bits
   always_comb begin
      p1_valid_in  = item_in_up.valid;
      p1_bypass_in = item_in_up.bypass;
      p1_word_in   = item_in_up.word;
      p1_sign_in   = item_in_up.sign;
      p1_zero_in   = (item_in_up.mant == 32'd0);
      p1_e_in      = item_in_up.expo;
      p1_m_in      = item_in_up.mant;
      p1_up_in     = item_in_up.mant[25];
      p1_sh_in     = 5'd25;
      for (int k = 0; k < 25; k++) begin
         if (item_in_up.mant[k]) p1_sh_in = 5'(24 - k);
      end
   end

   // Stage 2: shift to bit 24, round, drop the guard bit
   always_comb begin
      m1 = p1_up_ff ? (p1_m_ff >> 1) : (p1_m_ff << p1_sh_ff);
      e1 = p1_up_ff ? (p1_e_ff + 12'sd1) : (p1_e_ff - $signed({7'd0, p1_sh_ff}));
      m2 = (m1[1:0] == 2'b11) ? (m1 + 32'd1) : m1;
      m3 = m2[25] ? (m2 >> 1) : m2;
      e2 = m2[25] ? (e1 + 12'sd1) : e1;
      p2_valid_in  = p1_valid_ff;
      p2_bypass_in = p1_bypass_ff;
      p2_word_in   = p1_word_ff;
      p2_sign_in   = p1_sign_ff;
      p2_zero_in   = p1_zero_ff;
      p2_m_in      = m3 >> 1;
      p2_e_in      = e2 + 12'sd1;
   end

   // Final word: bypass word as is, infinity on overflow, subnormal or zero when tiny
   always_comb begin
      sub_sh = -12'sd126 - p2_e_ff;
      ef     = 8'(p2_e_ff + 12'sd127);
      if (p2_bypass_ff) begin
         out_word = p2_word_ff;
      end else if (p2_zero_ff) begin
         out_word = {p2_sign_ff, 31'd0};
      end else if (p2_e_ff >= 12'sd128) begin
         out_word = {p2_sign_ff, 8'hff, 23'd0};
      end else if (p2_e_ff >= -12'sd126) begin
         out_word = {p2_sign_ff, ef, p2_m_ff[22:0]};
      end else if (p2_e_ff >= -12'sd150) begin
         out_word = {p2_sign_ff, 8'd0, 23'(p2_m_ff >> sub_sh[4:0])};
      end else begin
         out_word = {p2_sign_ff, 31'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff  <= p1_valid_in;
         p1_bypass_ff <= p1_bypass_in;
         p1_word_ff   <= p1_word_in;
         p1_sign_ff   <= p1_sign_in;
         p1_zero_ff   <= p1_zero_in;
         p1_up_ff     <= p1_up_in;
         p1_sh_ff     <= p1_sh_in;
         p1_e_ff      <= p1_e_in;
         p1_m_ff      <= p1_m_in;
         p2_valid_ff  <= p2_valid_in;
         p2_bypass_ff <= p2_bypass_in;
         p2_word_ff   <= p2_word_in;
         p2_sign_ff   <= p2_sign_in;
         p2_zero_ff   <= p2_zero_in;
         p2_e_ff      <= p2_e_in;
         p2_m_ff      <= p2_m_in;
      end
   end

   assign out_valid = p2_valid_ff;

endmodule

/* rtl/float32_arith_unit.sv */
// float32_arith_unit: single-precision add, subtract, multiply, divide and conversions.
// Top level; instantiates fau_front, a row of fau_div_cell and fau_pack. Depends on fau_pkg.
//
// Usage:
//   Request channel (req_valid/req_ready) takes one item: a command (0 add, 1 subtract,
//   2 multiply, 3 divide, 4 float to int, 5 int to float) and two 32-bit operands.
//   Response channel (rsp_valid/rsp_ready) returns one 32-bit result word per item,
//   in request order.
//   An accepted item passes through 55 register stages: 3 front stages (the first
//   loads on the accepting edge), 49 division cells (one quotient bit each),
//   2 packing stages and the output register. Every command takes the same path,
//   so the order is kept.
//   Throughput is one item per cycle while req_ready is high; all stages advance together.
//   When the receiver stalls with a result held in the output register, the pipe keeps
//   moving as long as its last stage is empty; once an item waits there, req_ready
//   drops until the output register is taken.
//   Reset (synchronous, active high) empties every stage; no item is in flight after it.
module float32_arith_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_word
);
   import fau_pkg::*;

   fau_item_type chain [0:DivSteps];
   logic         en;
   logic         tail_valid;
   logic [31:0]  tail_word;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_word_ff, rsp_word_in;

   // Advance the pipe unless a finished item is blocked behind a held result
   assign en        = ~tail_valid | ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   fau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .command   (req_command),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .item_out  (chain[0])
   );

   // Division cells, one quotient bit per cell
   for (genvar g = 0; g < DivSteps; g++) begin : g_cell
      fau_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_item (chain[g]),
         .dn_item (chain[g+1])
      );
   end

   fau_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .item_in_up (chain[DivSteps]),
      .out_valid  (tail_valid),
      .out_word   (tail_word)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (en) begin
         rsp_valid_in = tail_valid | (rsp_valid_ff & ~rsp_ready);
         if (tail_valid) rsp_word_in = tail_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;

   // A new result appears only from an item at the end of the pipe
   a_rsp_from_tail: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(tail_valid))
      else $error("response raised without a finished item");

   // A finished item blocked by a held result stops intake
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (tail_valid && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("intake while the pipe tail is blocked");

   // Bypassed items never run the divider
   a_bypass_no_div: assert property (@(posedge clock) disable iff (reset)
      (chain[DivSteps].valid && chain[DivSteps].bypass) |-> !chain[DivSteps].div_op)
      else $error("bypassed item marked as divide");

   // A blocked tail item is still there next cycle
   a_tail_held: assert property (@(posedge clock) disable iff (reset)
      (tail_valid && rsp_valid && !rsp_ready) |=> tail_valid)
      else $error("blocked item lost from pipe tail");

endmodule

/* verif/float32_arith_unit_tb.sv */
// Testbench for float32_arith_unit: drives add, subtract, multiply, divide and conversion
// items and compares every result word against a bit-exact predictor or a hand-typed word.
// Depends on fau_pkg (command codes) and the float32_arith_unit RTL.
module float32_arith_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fau_pkg::*;

   localparam int LATENCY    = 55;
   localparam int RAND_ITEMS = 1800;
   localparam int STALL_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = 3'd0;
   logic [31:0] req_operand_a = 32'd0;
   logic [31:0] req_operand_b = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_word;

   logic [31:0] pending_words[$];
   int          fail_count = 0;
   int          result_count = 0;
   int          item_count = 0;
   int          idle_cycles = 0;
   bit          quiet_phase = 1'b0;
   bit          stall_phase = 1'b0;

   float32_arith_unit dut (.*);

   always #5 clock = ~clock;

   // Unpacked float: leading one at bit 24
   typedef struct {
      bit              is_zero;
      bit              is_sub;
      bit              is_spec;
      bit              sign;
      int              expo;
      logic [31:0]     sig;
   } flt_parts_type;

   function automatic flt_parts_type split_float(logic [31:0] w);
      flt_parts_type u;
      logic [7:0]  ef;
      logic [22:0] mf;
      int          i;
      ef = w[30:23];
      mf = w[22:0];
      u.sign = w[31];
      u.is_zero = 0; u.is_sub = 0; u.is_spec = 0;
      if (ef == 8'd0) begin
         if (mf == 23'd0) begin
            u.is_zero = 1; u.expo = -128; u.sig = 0;
         end else begin
            i = 22;
            while (i > 0 && !mf[i]) i--;
            u.is_sub = 1;
            u.expo = -126 - (24 - i);
            u.sig = {9'd0, mf} << (24 - i);
         end
      end else if (ef == 8'hff) begin
         u.is_spec = 1; u.expo = 255; u.sig = {9'd0, mf};
      end else begin
         u.expo = int'(ef) - 128;
         u.sig = {8'd0, 1'b1, mf} << 1;
      end
      return u;
   endfunction

   // Normalize, round (guard and LSB both set) and pack
   function automatic logic [31:0] pack_float(bit s, int e, logic [31:0] m);
      int         i;
      logic [7:0] ef;
      if (m == 0) return {s, 31'd0};
      i = 25;
      while (i >= 0 && !m[i]) i--;
      if (i == 25) begin
         m = m >> 1; e += 1;
      end else begin
         m = m << (24 - i); e -= 24 - i;
      end
      if (m[1:0] == 2'b11) m = m + 1;
      if (m[25]) begin
         m = m >> 1; e += 1;
      end
      m = m >> 1;
      e += 1;
      if (e >= 128) begin
         ef = 8'hff; m = 0;
      end else if (e >= -126) begin
         ef = 8'(e + 127);
      end else if (e >= -150) begin
         m = m >> (-126 - e); ef = 8'd0;
      end else begin
         m = 0; ef = 8'd0;
      end
      return {s, ef, m[22:0]};
   endfunction

   function automatic logic [31:0] float_sum(logic [31:0] a, logic [31:0] b);
      flt_parts_type x, y;
      int            ec;
      logic [31:0]   mc;
      bit            sc;
      x = split_float(a);
      y = split_float(b);
      if (x.expo >= y.expo) begin
         y.sig = (x.expo - y.expo >= 32) ? 32'd0 : y.sig >> (x.expo - y.expo);
         ec = x.expo;
      end else begin
         x.sig = (y.expo - x.expo >= 32) ? 32'd0 : x.sig >> (y.expo - x.expo);
         ec = y.expo;
      end
      if (x.sign == y.sign) begin
         mc = x.sig + y.sig; sc = x.sign;
      end else if (x.sig >= y.sig) begin
         mc = x.sig - y.sig; sc = x.sign;
      end else begin
         mc = y.sig - x.sig; sc = y.sign;
      end
      return pack_float(sc, ec, mc);
   endfunction

   function automatic logic [31:0] float_product(logic [31:0] a, logic [31:0] b);
      flt_parts_type x, y;
      logic [63:0]   p;
      x = split_float(a);
      y = split_float(b);
      p = 64'(x.sig) * 64'(y.sig);
      return pack_float(x.sign ^ y.sign, x.expo + y.expo + 2, p[56:25]);
   endfunction

   function automatic logic [31:0] float_quotient(logic [31:0] a, logic [31:0] b);
      flt_parts_type x, y;
      logic [63:0]   q;
      x = split_float(a);
      y = split_float(b);
      if (y.sig == 0) return PosInf;
      q = (64'(x.sig) << 24) / 64'(y.sig);
      return pack_float(x.sign ^ y.sign, x.expo - y.expo - 1, q[31:0]);
   endfunction

   function automatic logic [31:0] float_to_int(logic [31:0] f);
      flt_parts_type x;
      int            ue;
      logic [31:0]   mag;
      x = split_float(f);
      if (x.is_zero || x.is_sub) return 32'd0;
      if (x.is_spec) begin
         if (x.sig != 0) return f;
         return x.sign ? SignMask : IntMax;
      end
      ue = x.expo + 1;
      if (ue >= 31) return x.sign ? SignMask : IntMax;
      if (ue < 0) return 32'd0;
      mag = (ue <= 24) ? x.sig >> (24 - ue) : x.sig << (ue - 24);
      return x.sign ? 32'd0 - mag : mag;
   endfunction

   function automatic logic [31:0] int_to_float(logic [31:0] n);
      logic [31:0] m;
      int          i;
      if (n == 0) return 32'd0;
      m = n[31] ? 32'd0 - n : n;
      i = 31;
      while (i > 0 && !m[i]) i--;
      if (i > 23) m = m >> (i - 23);
      else m = m << (23 - i);
      return pack_float(n[31], i, m);
   endfunction

   function automatic logic [31:0] predict_word(logic [2:0] cmd, logic [31:0] a,
                                                logic [31:0] b);
      case (cmd)
         CMD_ADD:  return float_sum(a, b);
         CMD_SUB:  return float_sum(a, b ^ SignMask);
         CMD_MUL:  return float_product(a, b);
         CMD_DIV:  return float_quotient(a, b);
         CMD_FTOI: return float_to_int(a);
         CMD_ITOF: return int_to_float(a);
         default:  return 32'd0;
      endcase
   endfunction

   // Directed rows; known marks a hand-typed expected word
   typedef struct {
      logic [2:0]  cmd;
      logic [31:0] a;
      logic [31:0] b;
      bit          known;
      logic [31:0] word;
   } vector_row_type;

   vector_row_type vectors [25] = '{
      '{CMD_ADD,  32'h3f80_0000, 32'h3f80_0000, 1, 32'h4000_0000},
      '{CMD_SUB,  32'h3f80_0000, 32'h3f80_0000, 1, 32'h0000_0000},
      '{CMD_SUB,  32'hbf80_0000, 32'hbf80_0000, 1, 32'h8000_0000},
      '{CMD_ADD,  32'h7f7f_ffff, 32'h7f7f_ffff, 1, 32'h7f80_0000},
      '{CMD_ADD,  32'h4b80_0000, 32'h0000_0001, 0, 32'h0},
      '{CMD_ADD,  32'h7f80_0000, 32'hff80_0000, 0, 32'h0},
      '{CMD_MUL,  32'h0080_0000, 32'h0080_0000, 1, 32'h0000_0000},
      '{CMD_MUL,  32'h0080_0000, 32'h3f00_0000, 0, 32'h0},
      '{CMD_MUL,  32'hffff_ffff, 32'hffff_ffff, 0, 32'h0},
      '{CMD_MUL,  32'h3fff_ffff, 32'h3fff_ffff, 0, 32'h0},
      '{CMD_DIV,  32'h3f80_0000, 32'h0000_0000, 1, 32'h7f80_0000},
      '{CMD_DIV,  32'hbf80_0000, 32'h7f80_0000, 1, 32'h7f80_0000},
      '{CMD_DIV,  32'h3f80_0000, 32'h4040_0000, 0, 32'h0},
      '{CMD_DIV,  32'h0000_0001, 32'h7f7f_ffff, 0, 32'h0},
      '{CMD_FTOI, 32'h0000_0001, 32'h0,         1, 32'h0000_0000},
      '{CMD_FTOI, 32'h4f00_0000, 32'h0,         1, 32'h7fff_ffff},
      '{CMD_FTOI, 32'hcf00_0000, 32'h0,         1, 32'h8000_0000},
      '{CMD_FTOI, 32'hff80_0000, 32'h0,         1, 32'h8000_0000},
      '{CMD_FTOI, 32'h7fc0_0001, 32'h0,         1, 32'h7fc0_0001},
      '{CMD_FTOI, 32'hc0b0_0000, 32'h0,         0, 32'h0},
      '{CMD_ITOF, 32'h0000_0000, 32'h0,         1, 32'h0000_0000},
      '{CMD_ITOF, 32'h8000_0000, 32'h0,         1, 32'hcf00_0000},
      '{CMD_ITOF, 32'h7fff_ffff, 32'h0,         0, 32'h0},
      '{3'd6,     32'hffff_ffff, 32'hffff_ffff, 1, 32'h0000_0000},
      '{3'd7,     32'h1234_5678, 32'h9abc_def0, 1, 32'h0000_0000}
   };

   // Random float with a bias toward the interesting exponent ranges
   function automatic logic [31:0] pick_float();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         0: w[30:23] = 8'd0;
         1: w[30:23] = 8'hff;
         2: w[30:23] = 8'(126 + $urandom_range(0, 3));
         3: w[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7f_ffff;
         default: ;
      endcase
      return w;
   endfunction

   // Offer one item and wait for it to be taken; valid stays up between items
   // unless an idle gap is inserted
   task automatic send_item(logic [2:0] cmd, logic [31:0] a, logic [31:0] b,
                            logic [31:0] want);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_words.push_back(want);
      item_count++;
      @(negedge clock);
   endtask

   // Receiver: random stall bursts, one long hold-off, none at the end
   initial begin
      int burst;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_phase) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            stall_phase = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (pending_words.size() == 0) begin
            $error("result_word: unexpected result %h", rsp_result_word);
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_result_word !== want) begin
               $error("result_word: expected %h, actual %h", want, rsp_result_word);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("float32_arith_unit: mismatch");
         $finish;
      end
   end

   initial begin
      logic [2:0]  cmd;
      logic [31:0] a;
      logic [31:0] want;
      int          drain;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table; hand-typed words are expected as typed, the rest come from
      // the predictor
      foreach (vectors[k]) begin
         want = vectors[k].known ? vectors[k].word
                                 : predict_word(vectors[k].cmd, vectors[k].a, vectors[k].b);
         send_item(vectors[k].cmd, vectors[k].a, vectors[k].b, want);
      end

      // Random items; a long receiver hold-off partway in fills the pipe
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == 400) stall_phase = 1'b1;
         if (n == RAND_ITEMS - 200) quiet_phase = 1'b1;
         cmd = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
         a = (cmd == CMD_ITOF && $urandom_range(0, 1)) ? 32'($urandom) : pick_float();
         b = pick_float();
         send_item(cmd, a, b, predict_word(cmd, a, b));
      end
      req_valid <= 1'b0;

      drain = 0;
      while (pending_words.size() != 0 && drain < 20 * LATENCY + 4000) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 5) @(posedge clock);
      if (pending_words.size() != 0) begin
         $error("result_word: %0d expected results never arrived", pending_words.size());
         fail_count++;
      end
      $display("Sent %0d items across all six commands plus unused codes; %0d results checked.",
               item_count, result_count);
      if (fail_count == 0) begin
         $display("float32_arith_unit: match");
      end else begin
         $display("float32_arith_unit: mismatch");
      end
      $finish;
   end

   logic [31:0] b;
endmodule

/* files.f */
rtl/fau_pkg.sv
rtl/fau_front.sv
rtl/fau_div_cell.sv
rtl/fau_pack.sv
rtl/float32_arith_unit.sv
verif/float32_arith_unit_tb.sv
